// ===== hdl/fcf_pkg.sv =====
package fcf_pkg;

	// Saturating window counter width.
	localparam int CNT_W = 8;
	localparam int RATIO_W = CNT_W + 3;

	localparam int TIME_W = 48;
	localparam int CONF_W = 16;
	localparam int WIN_MS_W = 20;
	localparam int WIN_US_W = WIN_MS_W + 10;
	localparam int LIMIT_W = 15;
	localparam int HOLD_W = 8;
	localparam int CLS_W = 3;
	localparam int OUT_CNT_W = 8;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;
	localparam int IN_DATA_W = 88;
	localparam int OUT_DATA_W = 40;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLAT_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_HOLD = 2'd2;

	localparam logic [WIN_MS_W-1:0] WINDOW_MS_RESET = 20'd4000;
	localparam logic [LIMIT_W-1:0] FLAT_LIMIT_RESET = 15'd4500;
	localparam logic [HOLD_W-1:0] UPRIGHT_HOLD_RESET = 8'd6;
	localparam logic [WIN_US_W-1:0] US_PER_MS = 30'd1000;

	localparam logic [CLS_W-1:0] CLS_WALK = 3'd0;
	localparam logic [CLS_W-1:0] CLS_RUN = 3'd1;
	localparam logic [CLS_W-1:0] CLS_IDLE = 3'd2;
	localparam logic [CLS_W-1:0] CLS_TRANS = 3'd3;
	localparam logic [CLS_W-1:0] CLS_FALL = 3'd4;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_STARTED = 3'd1,
		EV_REJECTED = 3'd2,
		EV_ABORTED = 3'd3,
		EV_CONFIRMED = 3'd4,
		EV_RATIO_LOW = 3'd5
	} fcf_event_t;

	typedef struct packed {
		logic [WIN_US_W-1:0] window_us;
		logic [LIMIT_W-1:0] flat_limit;
		logic [HOLD_W-1:0] upright_hold;
	} fcf_cfg_t;

	// One classified item as it waits for the confirmation logic.
	typedef struct packed {
		logic flat;
		logic locomotion;
		logic idle;
		logic trans;
		logic fall;
		logic hold_zero;
		logic [CONF_W-1:0] conf;
		logic [TIME_W-1:0] time_us;
	} fcf_item_t;

endpackage

// ===== hdl/fall_confirmation_fsm.sv =====
// Fall confirmation state machine. It takes one classifier result per transaction
// on the s_ side and returns exactly one status result per transaction on the m_
// side, in order. A new result can be accepted every cycle while the output is not
// stalled, since the whole per-result update is one compare-and-count step in the
// confirmation logic. The flat test and upright-hold countdown are combinational
// at the input; the item is then registered in the queue and after that in the
// output register of the confirmation logic. A two-entry queue between the two
// halves lets the input take two more transactions while the output is stalled
// before s_tready drops. The window length register is converted to microseconds
// when it is written, so the elapsed-time check is a single 49-bit subtract and
// 48-bit compare per result. Write configuration only while no transaction is in
// flight.
module fall_confirmation_fsm (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [fcf_pkg::CFG_IDX_W-1:0] cfg_addr,
	input logic [fcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	// activity_class[2:0], confidence[18:3], roll_cdeg[34:19], time_us[82:35]
	input logic [fcf_pkg::IN_DATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// event_code[2:0], confirming[3], reported_confidence[19:4],
	// hit_count_out[27:20], total_count_out[35:28]
	output logic [fcf_pkg::OUT_DATA_W-1:0] m_tdata
);
	import fcf_pkg::*;

	fcf_cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	fcf_item_t push_item;
	logic pop_valid;
	logic pop_ready;
	fcf_item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_us <= WIN_US_W'(WINDOW_MS_RESET) * US_PER_MS;
			cfg_q.flat_limit <= FLAT_LIMIT_RESET;
			cfg_q.upright_hold <= UPRIGHT_HOLD_RESET;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_WINDOW: cfg_q.window_us <= WIN_US_W'(cfg_wdata[WIN_MS_W-1:0]) * US_PER_MS;
				REG_FLAT_LIMIT: cfg_q.flat_limit <= cfg_wdata[LIMIT_W-1:0];
				REG_UPRIGHT_HOLD: cfg_q.upright_hold <= cfg_wdata[HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fcf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item)
	);

	fcf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item)
	);

	fcf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

// ===== hdl/fcf_front.sv =====
module fcf_front (
	input logic clk,
	input logic arst_n,
	input fcf_pkg::fcf_cfg_t cfg,
	input logic s_tvalid,
	output logic s_tready,
	input logic [fcf_pkg::IN_DATA_W-1:0] s_tdata,
	output logic push_valid,
	input logic push_ready,
	output fcf_pkg::fcf_item_t push_item
);
	import fcf_pkg::*;

	logic [CLS_W-1:0] cls;
	logic signed [16:0] roll;
	logic signed [16:0] lim;
	logic flat;
	logic [HOLD_W-1:0] countdown_q;
	logic [HOLD_W-1:0] countdown_n;
	logic accept;

	assign cls = s_tdata[2:0];
	assign roll = {s_tdata[34], s_tdata[34:19]};
	assign lim = {2'b00, cfg.flat_limit};
	assign flat = (roll > -lim) && (roll < lim);

	assign s_tready = push_ready;
	assign push_valid = s_tvalid;
	assign accept = s_tvalid && push_ready;

	// Any tilted sample reloads the upright memory; flat samples drain it.
	always_comb begin
		if (!flat) begin
			countdown_n = cfg.upright_hold;
		end else if (countdown_q != '0) begin
			countdown_n = countdown_q - 1'b1;
		end else begin
			countdown_n = countdown_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= '0;
		end else if (accept) begin
			countdown_q <= countdown_n;
		end
	end

	always_comb begin
		push_item.flat = flat;
		push_item.locomotion = (cls == CLS_WALK) || (cls == CLS_RUN);
		push_item.idle = (cls == CLS_IDLE);
		push_item.trans = (cls == CLS_TRANS);
		push_item.fall = (cls == CLS_FALL);
		push_item.hold_zero = (countdown_n == '0);
		push_item.conf = s_tdata[18:3];
		push_item.time_us = s_tdata[82:35];
	end

endmodule

// ===== hdl/fcf_queue.sv =====
module fcf_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input fcf_pkg::fcf_item_t push_item,
	output logic pop_valid,
	input logic pop_ready,
	output fcf_pkg::fcf_item_t pop_item
);
	import fcf_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	fcf_item_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0] fill_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (fill_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_item = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/fcf_back.sv =====
module fcf_back (
	input logic clk,
	input logic arst_n,
	input fcf_pkg::fcf_cfg_t cfg,
	input logic pop_valid,
	output logic pop_ready,
	input fcf_pkg::fcf_item_t pop_item,
	output logic m_tvalid,
	input logic m_tready,
	output logic [fcf_pkg::OUT_DATA_W-1:0] m_tdata
);
	import fcf_pkg::*;

	typedef enum logic {
		ST_NORMAL,
		ST_CONFIRM
	} state_t;

	state_t state_q;
	state_t state_n;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] start_n;
	logic [CONF_W-1:0] trig_q;
	logic [CONF_W-1:0] trig_n;
	logic [CNT_W-1:0] hit_q;
	logic [CNT_W-1:0] hit_n;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] total_n;
	logic [CNT_W-1:0] hit_inc;
	logic [CNT_W-1:0] total_inc;
	logic [CNT_W-1:0] hit_upd;
	logic [CNT_W-1:0] total_upd;
	logic [TIME_W:0] elapsed;
	logic expired;
	logic ratio_ok;
	fcf_event_t event_n;
	logic [CONF_W-1:0] rep_n;
	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic take;

	assign pop_ready = !out_valid_q || m_tready;
	assign take = pop_valid && pop_ready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	// Counters in the window stop at all ones.
	assign total_inc = (total_q == '1) ? total_q : total_q + 1'b1;
	assign hit_inc = (hit_q == '1) ? hit_q : hit_q + 1'b1;

	// Counter values after a counted result inside an open window.
	assign total_upd = pop_item.trans ? total_q : total_inc;
	assign hit_upd = (!pop_item.trans && pop_item.idle && pop_item.flat) ? hit_inc : hit_q;

	// A timestamp earlier than the window start reads as a borrow and never expires.
	assign elapsed = {1'b0, pop_item.time_us} - {1'b0, start_q};
	assign expired = !elapsed[TIME_W] && (elapsed[TIME_W-1:0] >= TIME_W'(cfg.window_us));

	assign ratio_ok = (total_upd != '0) &&
		(RATIO_W'(hit_upd) * RATIO_W'(5) >= RATIO_W'(total_upd) * RATIO_W'(3));

	always_comb begin
		state_n = state_q;
		start_n = start_q;
		trig_n = trig_q;
		hit_n = hit_q;
		total_n = total_q;
		event_n = EV_NONE;
		rep_n = pop_item.conf;
		case (state_q)
			ST_NORMAL: begin
				if (pop_item.fall) begin
					if (pop_item.hold_zero) begin
						event_n = EV_REJECTED;
					end else begin
						state_n = ST_CONFIRM;
						start_n = pop_item.time_us;
						trig_n = pop_item.conf;
						hit_n = '0;
						total_n = '0;
						event_n = EV_STARTED;
					end
				end
			end
			ST_CONFIRM: begin
				if (pop_item.locomotion && !pop_item.flat) begin
					state_n = ST_NORMAL;
					event_n = EV_ABORTED;
				end else begin
					total_n = total_upd;
					hit_n = hit_upd;
					if (expired) begin
						state_n = ST_NORMAL;
						if (ratio_ok) begin
							event_n = EV_CONFIRMED;
							rep_n = trig_q;
						end else begin
							event_n = EV_RATIO_LOW;
						end
					end
				end
			end
			default: begin
				state_n = ST_NORMAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NORMAL;
			start_q <= '0;
			trig_q <= '0;
			hit_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (take) begin
				state_q <= state_n;
				start_q <= start_n;
				trig_q <= trig_n;
				hit_q <= hit_n;
				total_q <= total_n;
				out_data_q <= {4'b0000, OUT_CNT_W'(total_n), OUT_CNT_W'(hit_n), rep_n,
					(state_n == ST_CONFIRM), event_n};
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/fcf_checker.sv =====
module fcf_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [fcf_pkg::OUT_DATA_W-1:0] m_tdata
);
	import fcf_pkg::*;

	logic [2:0] ev;
	logic open_win;
	logic [OUT_CNT_W-1:0] hits;
	logic [OUT_CNT_W-1:0] total;

	assign ev = m_tdata[2:0];
	assign open_win = m_tdata[3];
	assign hits = m_tdata[27:20];
	assign total = m_tdata[35:28];

	// A stalled result must not change under the consumer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A newly opened window always starts with empty counters.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (ev == EV_STARTED) |-> open_win && (hits == '0) && (total == '0))
		else $error("window start with stale counters");

	// Closing events leave the window closed; other events cannot close it.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (ev == EV_CONFIRMED || ev == EV_RATIO_LOW || ev == EV_ABORTED ||
		ev == EV_REJECTED) |-> !open_win)
		else $error("window open after a closing event");

	// A confirmation needs counted results and hits never outnumber them.
	a_confirm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (ev == EV_CONFIRMED) |-> (total != '0) && (hits <= total))
		else $error("confirmation with bad counts");

endmodule

bind fall_confirmation_fsm fcf_checker u_fcf_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import fcf_pkg::*;

	localparam logic [CLS_W-1:0] CLS_UNKNOWN = 3'd5;
	localparam logic [CLS_W-1:0] CLS_SPARE_HI = 3'd7;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int ROLL_SPAN = 18000;
	localparam int WINDOW_MS_MAX = 600000;
	localparam int FLAT_LIMIT_MAX = 18000;
	localparam int HOLD_MAX = 255;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int TAIL_CYCLES = 10;
	localparam int PRINT_LIMIT = 20;

	typedef struct packed {
		fcf_event_t ev;
		logic confirming;
		logic [CONF_W-1:0] conf;
		logic [OUT_CNT_W-1:0] hits;
		logic [OUT_CNT_W-1:0] total;
	} fall_status_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	fall_confirmation_fsm u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Predictor copy of the configuration and of the confirmation state.
	logic [WIN_MS_W-1:0] window_ms_cfg = WINDOW_MS_RESET;
	logic [LIMIT_W-1:0] flat_limit_cfg = FLAT_LIMIT_RESET;
	logic [HOLD_W-1:0] hold_cfg = UPRIGHT_HOLD_RESET;
	logic in_window = 1'b0;
	logic [TIME_W-1:0] window_start = '0;
	logic [CONF_W-1:0] trigger_conf = '0;
	logic [CNT_W-1:0] hit_cnt = '0;
	logic [CNT_W-1:0] total_cnt = '0;
	logic [HOLD_W-1:0] upright_cnt = '0;

	fall_status_t status_q[$];
	logic [63:0] wall_us = '0;
	int src_idle_pct;
	int snk_idle_pct;
	int sink_hold = 0;
	int items_sent = 0;
	int results_seen = 0;
	int cfg_writes = 0;
	int mismatches = 0;
	int stall_cycles = 0;
	int ev_tally[8] = '{default: 0};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic fall_status_t fall_predict(input logic [CLS_W-1:0] cls,
			input logic [CONF_W-1:0] conf, input logic signed [15:0] roll,
			input logic [TIME_W-1:0] now);
		fall_status_t r;
		logic flat;
		int lim;
		lim = int'(flat_limit_cfg);
		flat = ($signed(roll) > -lim) && ($signed(roll) < lim);
		if (!flat)
			upright_cnt = hold_cfg;
		else if (upright_cnt != 0)
			upright_cnt = upright_cnt - 1'b1;
		r.ev = EV_NONE;
		r.conf = conf;
		if (!in_window) begin
			if (cls == CLS_FALL) begin
				if (upright_cnt == 0) begin
					r.ev = EV_REJECTED;
				end else begin
					in_window = 1'b1;
					window_start = now;
					trigger_conf = conf;
					hit_cnt = '0;
					total_cnt = '0;
					r.ev = EV_STARTED;
				end
			end
		end else if ((cls == CLS_WALK || cls == CLS_RUN) && !flat) begin
			in_window = 1'b0;
			r.ev = EV_ABORTED;
		end else begin
			if (cls != CLS_TRANS) begin
				if (total_cnt != CNT_MAX)
					total_cnt = total_cnt + 1'b1;
				if (cls == CLS_IDLE && flat && hit_cnt != CNT_MAX)
					hit_cnt = hit_cnt + 1'b1;
			end
			// A timestamp behind the window start never closes the window.
			if (now >= window_start &&
					(64'(now) - 64'(window_start)) >= 64'(window_ms_cfg) * 64'd1000) begin
				if (total_cnt != 0 && int'(hit_cnt) * 5 >= int'(total_cnt) * 3) begin
					r.ev = EV_CONFIRMED;
					r.conf = trigger_conf;
				end else begin
					r.ev = EV_RATIO_LOW;
				end
				in_window = 1'b0;
			end
		end
		r.confirming = in_window;
		r.hits = OUT_CNT_W'(hit_cnt);
		r.total = OUT_CNT_W'(total_cnt);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	// Result checker: each accepted status transaction against the oldest prediction.
	always @(posedge clk) begin : status_check
		fall_status_t want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			results_seen++;
			if (status_q.size() == 0) begin
				report_mismatch("unexpected result", 64'(m_tdata), '0);
			end else begin
				want = status_q.pop_front();
				if (m_tdata[2:0] !== want.ev)
					report_mismatch("event_code", 64'(m_tdata[2:0]), 64'(want.ev));
				if (m_tdata[3] !== want.confirming)
					report_mismatch("confirming", 64'(m_tdata[3]), 64'(want.confirming));
				if (m_tdata[19:4] !== want.conf)
					report_mismatch("reported_confidence", 64'(m_tdata[19:4]), 64'(want.conf));
				if (m_tdata[27:20] !== want.hits)
					report_mismatch("hit_count_out", 64'(m_tdata[27:20]), 64'(want.hits));
				if (m_tdata[35:28] !== want.total)
					report_mismatch("total_count_out", 64'(m_tdata[35:28]), 64'(want.total));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("fall_confirmation_fsm regression: fail");
				$finish;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready = 1'b0;
				sink_hold--;
			end else begin
				m_tready = ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	task automatic send_reading(input logic [CLS_W-1:0] cls, input logic [CONF_W-1:0] conf,
			input logic signed [15:0] roll, input logic [TIME_W-1:0] now);
		fall_status_t want;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata = IN_DATA_W'({now, roll, conf, cls});
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		want = fall_predict(cls, conf, roll, now);
		status_q.push_back(want);
		ev_tally[want.ev]++;
		items_sent++;
	endtask

	task automatic settle_pipeline();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle_pipeline();
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			REG_WINDOW: window_ms_cfg = WIN_MS_W'(val);
			REG_FLAT_LIMIT: flat_limit_cfg = LIMIT_W'(val);
			REG_UPRIGHT_HOLD: hold_cfg = HOLD_W'(val);
			default: ;
		endcase
		cfg_writes++;
	endtask

	function automatic logic signed [15:0] flat_roll();
		int lim;
		int v;
		lim = int'(flat_limit_cfg);
		if (lim == 0)
			return '0;
		v = int'($urandom_range(0, 2 * lim - 2)) - (lim - 1);
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] tilted_roll();
		int mag;
		mag = $urandom_range(int'(flat_limit_cfg), ROLL_SPAN);
		return $urandom_range(1) ? 16'(-mag) : 16'(mag);
	endfunction

	function automatic logic [TIME_W-1:0] random_time();
		return TIME_W'({$urandom, $urandom});
	endfunction

	// Advances the stimulus clock, now and then stepping back or jumping.
	function automatic logic [TIME_W-1:0] tick(input logic [63:0] step);
		int r;
		r = $urandom_range(99);
		if (r < 3 && wall_us > step)
			wall_us = wall_us - step;
		else if (r == 3)
			wall_us = 64'(random_time() >> 1);
		else
			wall_us = wall_us + step;
		if (wall_us > 64'(TIME_MAX))
			wall_us = 64'($urandom_range(0, 1000));
		return wall_us[TIME_W-1:0];
	endfunction

	// Mostly a plausible fall: posture, trigger, then readings across the window.
	task automatic run_fall_episode();
		int body_n;
		int r;
		logic [63:0] win_us;
		logic [63:0] step;
		logic [CLS_W-1:0] cls;
		logic signed [15:0] roll;
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(1, 3))
				send_reading(CLS_W'($urandom_range(0, 7)), CONF_W'($urandom), 16'($urandom),
					random_time());
			return;
		end
		win_us = 64'(window_ms_cfg) * 64'd1000;
		repeat ($urandom_range(0, 3)) begin
			cls = CLS_W'($urandom_range(0, 7));
			if (cls == CLS_FALL)
				cls = CLS_TRANS;
			roll = $urandom_range(1) ? tilted_roll() : flat_roll();
			send_reading(cls, CONF_W'($urandom), roll, tick(win_us / 8 + 1));
		end
		roll = ($urandom_range(99) < 70) ? flat_roll() : tilted_roll();
		send_reading(CLS_FALL, CONF_W'($urandom), roll, tick(win_us / 8 + 1));
		body_n = $urandom_range(1, 12);
		step = win_us / body_n;
		repeat (body_n) begin
			r = $urandom_range(99);
			roll = flat_roll();
			if (r < 55) begin
				cls = CLS_IDLE;
			end else if (r < 65) begin
				cls = CLS_TRANS;
			end else if (r < 75) begin
				cls = CLS_W'($urandom_range(CLS_UNKNOWN, CLS_SPARE_HI));
			end else if (r < 81) begin
				cls = CLS_FALL;
			end else if (r < 87) begin
				cls = CLS_IDLE;
				roll = tilted_roll();
			end else if (r < 94) begin
				cls = $urandom_range(1) ? CLS_WALK : CLS_RUN;
			end else begin
				cls = $urandom_range(1) ? CLS_WALK : CLS_RUN;
				roll = tilted_roll();
			end
			send_reading(cls, CONF_W'($urandom), roll,
				tick(step * $urandom_range(60, 140) / 100 + $urandom_range(0, 2)));
		end
	endtask

	task automatic pick_random_config();
		int r;
		logic [CFG_DATA_W-1:0] win;
		logic [CFG_DATA_W-1:0] lim;
		logic [CFG_DATA_W-1:0] hold;
		r = $urandom_range(99);
		if (r < 20)
			win = '0;
		else if (r < 70)
			win = CFG_DATA_W'($urandom_range(1, 100));
		else if (r < 90)
			win = WINDOW_MS_RESET;
		else
			win = CFG_DATA_W'($urandom_range(0, WINDOW_MS_MAX));
		r = $urandom_range(99);
		if (r < 10)
			lim = '0;
		else if (r < 20)
			lim = CFG_DATA_W'(FLAT_LIMIT_MAX);
		else
			lim = CFG_DATA_W'($urandom_range(100, 9000));
		r = $urandom_range(99);
		if (r < 10)
			hold = '0;
		else if (r < 20)
			hold = CFG_DATA_W'(HOLD_MAX);
		else
			hold = CFG_DATA_W'($urandom_range(1, 10));
		write_cfg(REG_WINDOW, win);
		write_cfg(REG_FLAT_LIMIT, lim);
		write_cfg(REG_UPRIGHT_HOLD, hold);
	endtask

	// Reset settings: boundaries of the flat test, every class, both window outcomes,
	// abort, timestamps behind the window start and at the top of the range.
	task automatic test_default_settings();
		send_reading(CLS_FALL, 16'h1234, 16'sd0, 48'd100);
		send_reading(CLS_WALK, 16'd1, 16'sd4500, 48'd200);
		send_reading(CLS_FALL, 16'hFFFF, 16'sd4499, 48'd1000);
		send_reading(CLS_IDLE, 16'd2, -16'sd4499, 48'd2000);
		send_reading(CLS_TRANS, 16'd3, 16'sd0, 48'd3000);
		send_reading(CLS_UNKNOWN, 16'd4, 16'sd0, 48'd4000);
		send_reading(CLS_SPARE_HI, 16'd5, 16'sd0, 48'd5000);
		send_reading(CLS_RUN, 16'd6, 16'sd100, 48'd6000);
		send_reading(CLS_FALL, 16'd7, 16'sd0, 48'd7000);
		send_reading(CLS_IDLE, 16'd8, 16'sd0, 48'd4001000);
		send_reading(CLS_TRANS, 16'd9, 16'sd0, 48'd4002000);
		send_reading(CLS_RUN, 16'd10, -16'sd4500, 48'd5000000);
		send_reading(CLS_FALL, 16'h0000, 16'sd0, 48'd5000000);
		send_reading(CLS_IDLE, 16'd11, 16'sd0, 48'd9000000);
		send_reading(CLS_WALK, 16'd12, 16'sd18000, 48'd9100000);
		send_reading(CLS_FALL, 16'd13, -16'sd18000, 48'd9200000);
		send_reading(CLS_WALK, 16'd14, 16'sh8000, 48'd9300000);
		send_reading(CLS_FALL, 16'd15, 16'sh7FFF, TIME_MAX - 5);
		send_reading(CLS_IDLE, 16'd16, 16'sd0, 48'd20);
		send_reading(CLS_IDLE, 16'd17, 16'sd0, TIME_MAX);
	endtask

	// A zero-length window closes on the first reading at or after its start.
	task automatic test_zero_window();
		write_cfg(REG_WINDOW, '0);
		send_reading(CLS_WALK, 16'd20, 16'sd9000, 48'd100);
		send_reading(CLS_FALL, 16'hBEEF, 16'sd0, 48'd500);
		send_reading(CLS_IDLE, 16'd21, 16'sd0, 48'd499);
		send_reading(CLS_IDLE, 16'd22, 16'sd0, 48'd500);
		send_reading(CLS_FALL, 16'd23, 16'sd0, 48'd600);
		send_reading(CLS_TRANS, 16'd24, 16'sd0, 48'd600);
		write_cfg(REG_WINDOW, WINDOW_MS_RESET);
	endtask

	task automatic test_upright_hold();
		write_cfg(REG_UPRIGHT_HOLD, '0);
		send_reading(CLS_WALK, 16'd30, 16'sd9000, 48'd1000);
		send_reading(CLS_FALL, 16'd31, 16'sd9000, 48'd2000);
		write_cfg(REG_UPRIGHT_HOLD, CFG_DATA_W'(HOLD_MAX));
		send_reading(CLS_WALK, 16'd32, -16'sd9000, 48'd3000);
		repeat (10)
			send_reading(CLS_IDLE, 16'd33, 16'sd0, 48'd4000);
		send_reading(CLS_FALL, 16'hA5A5, 16'sd0, 48'd5000);
		send_reading(CLS_IDLE, 16'd34, 16'sd0, 48'd4005000);
	endtask

	task automatic test_flat_limits();
		write_cfg(REG_FLAT_LIMIT, '0);
		send_reading(CLS_IDLE, 16'd40, 16'sd0, 48'd100);
		send_reading(CLS_FALL, 16'd41, 16'sd0, 48'd200);
		send_reading(CLS_IDLE, 16'd42, 16'sd0, 48'd300);
		send_reading(CLS_WALK, 16'd43, 16'sd0, 48'd400);
		write_cfg(REG_FLAT_LIMIT, CFG_DATA_W'(FLAT_LIMIT_MAX));
		send_reading(CLS_WALK, 16'd44, 16'sd18000, 48'd500);
		send_reading(CLS_FALL, 16'd45, 16'sd17999, 48'd600);
		send_reading(CLS_WALK, 16'd46, -16'sd17999, 48'd700);
		send_reading(CLS_RUN, 16'd47, -16'sd18000, 48'd800);
		write_cfg(REG_FLAT_LIMIT, CFG_DATA_W'(FLAT_LIMIT_RESET));
	endtask

	// Longest window, enough idle readings to pin both counters at their maximum.
	task automatic test_counter_saturation();
		write_cfg(REG_WINDOW, CFG_DATA_W'(WINDOW_MS_MAX));
		write_cfg(REG_UPRIGHT_HOLD, CFG_DATA_W'(UPRIGHT_HOLD_RESET));
		send_reading(CLS_WALK, 16'd50, 16'sd9000, 48'd0);
		send_reading(CLS_FALL, 16'hC0DE, 16'sd0, 48'd0);
		for (int i = 1; i <= 265; i++)
			send_reading(CLS_IDLE, CONF_W'(i), 16'sd0, TIME_W'(i));
		send_reading(CLS_IDLE, 16'd51, 16'sd0, 48'd600000000);
		send_reading(CLS_FALL, 16'd52, 16'sd0, 48'd600000001);
	endtask

	// The receiver holds off while the sender keeps offering, so the block backs up.
	task automatic test_output_backpressure();
		int start;
		settle_pipeline();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		sink_hold = HOLD_OFF_CYCLES;
		start = items_sent;
		while (items_sent - start < 40)
			run_fall_episode();
		settle_pipeline();
	endtask

	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n);
		int stop;
		int next_cfg;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		stop = items_sent + n;
		while (items_sent < stop) begin
			pick_random_config();
			next_cfg = items_sent + $urandom_range(40, 100);
			while (items_sent < next_cfg && items_sent < stop)
				run_fall_episode();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		src_idle_pct = 10;
		snk_idle_pct = 78;
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_settings();
		test_zero_window();
		test_upright_hold();
		test_flat_limits();
		test_counter_saturation();
		test_random_traffic(10, 78, 330);
		test_random_traffic(78, 10, 330);
		test_output_backpressure();
		test_random_traffic(0, 0, 330);

		settle_pipeline();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		$display("Sent %0d classifier readings, checked %0d status results, %0d register writes.",
			items_sent, results_seen, cfg_writes);
		$display("Windows started %0d, rejected %0d, aborted %0d, confirmed %0d, ratio low %0d.",
			ev_tally[EV_STARTED], ev_tally[EV_REJECTED], ev_tally[EV_ABORTED],
			ev_tally[EV_CONFIRMED], ev_tally[EV_RATIO_LOW]);
		if (mismatches == 0)
			$display("fall_confirmation_fsm regression: pass");
		else
			$display("fall_confirmation_fsm regression: fail");
		$finish;
	end

endmodule
